// ===== hdl/rsdac_pkg.sv =====
// rsdac_pkg: shared types and constants of the row scan centroid unit
// no dependencies
package rsdac_pkg;

  localparam int WIDTH_DEF      = 320;
  localparam int MISS_LIMIT_DEF = 5;

  localparam int COORD_W   = 10;
  localparam int SCOORD_W  = 11;
  localparam int SUM_W     = 20;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int MISS_W    = 4;

  localparam logic [COORD_W-1:0] LEFT_WIN_RST   = 10'd130;
  localparam logic [COORD_W-1:0] RIGHT_WIN_RST  = 10'd130;
  localparam logic [COORD_W-1:0] BRANCH_MIN_RST = 10'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_WIN   = 2'd0,
    REG_RIGHT_WIN  = 2'd1,
    REG_BRANCH_MIN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/rsdac_if.sv =====
// rsdac_pixel_if and rsdac_result_if: valid/ready channels of the unit
// depends on rsdac_pkg
interface rsdac_pixel_if;
  import rsdac_pkg::*;
  logic               valid;
  logic               ready;
  logic               pixel;
  logic [COORD_W-1:0] row_number;
  logic               row_end;
  logic               frame_begin;

  modport source (output valid, pixel, row_number, row_end, frame_begin, input ready);
  modport sink (input valid, pixel, row_number, row_end, frame_begin, output ready);
endinterface

interface rsdac_result_if;
  import rsdac_pkg::*;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  out_row;
  logic                row_tracked;
  logic [SCOORD_W-1:0] straight_center;
  logic [SCOORD_W-1:0] side_center;
  logic                branch_found;
  logic [SCOORD_W-1:0] branch_col;
  logic [COORD_W-1:0]  branch_count;
  logic [SCOORD_W-1:0] raw_left_edge;
  logic [SCOORD_W-1:0] raw_right_edge;
  logic [COORD_W-1:0]  used_left_edge;

  modport source (output valid, out_row, row_tracked, straight_center, side_center,
                  branch_found, branch_col, branch_count, raw_left_edge,
                  raw_right_edge, used_left_edge, input ready);
  modport sink (input valid, out_row, row_tracked, straight_center, side_center,
                branch_found, branch_col, branch_count, raw_left_edge,
                raw_right_edge, used_left_edge, output ready);
endinterface

// ===== hdl/row_scan_dual_anchor_centroid_unit.sv =====
// row_scan_dual_anchor_centroid_unit: lane edge and window centroid tracker
// depends on rsdac_pkg, rsdac_if, rsdac_row_buf and rsdac_div
//
// pixels: one mask pixel per transfer, columns 0 to WIDTH-1, rows bottom to top;
// row_end marks the last pixel of a row, frame_begin the first pixel of a frame.
// results: one transfer per row, holding edges, window centroids and branch data.
// wr_en/wr_index/wr_data: register writes, to be made only while no row is in flight.
// Pixels are taken one per cycle into the row memory. The row_end pixel starts
// the row evaluation and pixels is not ready until it is finished: an edge pass
// over the row memory, a window pass and up to three divisions on the shared
// divider, one after another, since there is a single read port and one divider.
// The result sits in an output register; pixel intake of the next row goes on
// while it waits, but a stalled receiver holds that row's evaluation at its end
// and pixel intake with it. Reset clears the control state and loads the register
// defaults; row memory is not cleared, so columns past the end of a short row
// keep what earlier rows wrote there.
module row_scan_dual_anchor_centroid_unit #(
  parameter int WIDTH      = rsdac_pkg::WIDTH_DEF,
  parameter int MISS_LIMIT = rsdac_pkg::MISS_LIMIT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  rsdac_pixel_if.sink                           pixels,
  rsdac_result_if.source                        results,
  input  logic                                  wr_en,
  input  logic [rsdac_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [rsdac_pkg::COORD_W-1:0]         wr_data
);
  import rsdac_pkg::*;

  localparam int AW  = $clog2(WIDTH);
  localparam int CPW = $clog2(WIDTH + 1);
  localparam int HALF = WIDTH / 2;

  typedef enum logic [2:0] {
    S_IDLE, S_EDGE, S_EVAL, S_WIN, S_DIV_L, S_DIV_R, S_DIV_B, S_OUT
  } state_t;

  state_t state;

  logic [COORD_W-1:0]  lww, rww, bmin_reg;
  logic [CPW-1:0]      cp;
  logic [COORD_W-1:0]  last_l;
  logic [SCOORD_W-1:0] last_r;
  logic [MISS_W-1:0]   missing;
  logic [COORD_W-1:0]  row_reg;

  logic [AW-1:0]       sc;
  logic                scan_on;
  logic                p_valid;
  logic [AW-1:0]       p_col;
  logic                rd_data;

  logic                edge_found;
  logic [AW-1:0]       raw_l, raw_r;

  logic                tracked;
  logic [COORD_W-1:0]  left_e;
  logic [SCOORD_W-1:0] right_e, l_hi, r_lo;

  logic [SUM_W-1:0]    sum_l, sum_r, sum_b;
  logic [CNT_W-1:0]    cnt_l, cnt_r, cnt_b;
  logic [SCOORD_W-1:0] c_l, c_r, c_b;
  logic                b_found;
  logic                div_wait;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                acc;
  logic [CPW-1:0]      cp_eff;
  logic                wr_mem;
  logic [CNT_W-1:0]    bmin_eff;
  logic [SCOORD_W-1:0] col;
  logic [COORD_W+1:0]  cl_def;
  logic [SCOORD_W-1:0] cl_sat;
  logic signed [SCOORD_W+1:0] cr_def;
  logic [SCOORD_W-1:0] cr_sat;
  logic [MISS_W-1:0]   missing_new;
  logic [COORD_W-1:0]  left_v;
  logic [SCOORD_W-1:0] right_v;
  logic [COORD_W:0]    lhi_sum;

  assign pixels.ready = state == S_IDLE;
  assign acc    = pixels.valid && pixels.ready;
  assign cp_eff = pixels.frame_begin ? '0 : cp;
  assign wr_mem = acc && (cp_eff < CPW'(WIDTH));

  assign bmin_eff = (bmin_reg == '0) ? CNT_W'(1) : {1'b0, bmin_reg};
  assign col      = SCOORD_W'(p_col);

  always_comb begin
    cl_def = {2'b0, left_e} + {3'b0, lww[COORD_W-1:1]};
    cl_sat = (cl_def > 12'd1023) ? SCOORD_W'(1023) : {1'b0, cl_def[COORD_W-1:0]};
    cr_def = $signed({2'b0, right_e}) - $signed({4'b0, rww[COORD_W-1:1]});
    cr_sat = (cr_def > 13'sd1023) ? SCOORD_W'(1023) : cr_def[SCOORD_W-1:0];
  end

  always_comb begin
    if (edge_found) begin
      missing_new = '0;
      left_v      = COORD_W'(raw_l);
      right_v     = SCOORD_W'(raw_r);
    end else begin
      missing_new = (missing == '1) ? missing : missing + 1'b1;
      left_v      = last_l;
      right_v     = last_r;
    end
    lhi_sum = {1'b0, left_v} + {1'b0, lww};
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_DIV_L: begin
        div_req.start    = !div_wait && cnt_l != '0;
        div_req.dividend = sum_l;
        div_req.divisor  = cnt_l;
      end
      S_DIV_R: begin
        div_req.start    = !div_wait && cnt_r != '0;
        div_req.dividend = sum_r;
        div_req.divisor  = cnt_r;
      end
      S_DIV_B: begin
        div_req.start    = !div_wait && cnt_b >= bmin_eff;
        div_req.dividend = sum_b;
        div_req.divisor  = cnt_b;
      end
      default: div_req = '0;
    endcase
  end

  rsdac_row_buf #(.WIDTH(WIDTH)) u_row_buf (
    .clk     (clk),
    .wr_en   (wr_mem),
    .wr_addr (cp_eff[AW-1:0]),
    .wr_data (pixels.pixel),
    .rd_addr (sc),
    .rd_data (rd_data)
  );

  rsdac_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lww           <= LEFT_WIN_RST;
      rww           <= RIGHT_WIN_RST;
      bmin_reg      <= BRANCH_MIN_RST;
      cp            <= '0;
      missing       <= '0;
      last_l        <= COORD_W'(HALF);
      last_r        <= SCOORD_W'(HALF) + SCOORD_W'(RIGHT_WIN_RST[COORD_W-1:1]);
      scan_on       <= 1'b0;
      p_valid       <= 1'b0;
      div_wait      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_LEFT_WIN:   lww      <= wr_data;
          REG_RIGHT_WIN:  rww      <= wr_data;
          REG_BRANCH_MIN: bmin_reg <= wr_data;
          default: ;
        endcase
      end

      if (results.valid && results.ready && state != S_OUT) begin
        results.valid <= 1'b0;
      end

      // memory read pipeline shared by both passes
      p_valid <= scan_on;
      p_col   <= sc;
      if (scan_on) begin
        sc <= sc + 1'b1;
        if (sc == AW'(WIDTH - 1)) begin
          scan_on <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (acc) begin
            if (pixels.frame_begin) begin
              missing <= '0;
              last_l  <= COORD_W'(HALF);
              last_r  <= SCOORD_W'(HALF) + SCOORD_W'(rww[COORD_W-1:1]);
            end
            if (pixels.row_end) begin
              cp         <= '0;
              row_reg    <= pixels.row_number;
              state      <= S_EDGE;
              scan_on    <= 1'b1;
              sc         <= '0;
              edge_found <= 1'b0;
            end else begin
              cp <= wr_mem ? cp_eff + 1'b1 : cp_eff;
            end
          end
        end
        S_EDGE: begin
          if (p_valid && rd_data) begin
            if (!edge_found) begin
              raw_l <= p_col;
            end
            edge_found <= 1'b1;
            raw_r      <= p_col;
          end
          if (!scan_on && !p_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          missing <= missing_new;
          if (edge_found) begin
            last_l <= left_v;
            last_r <= right_v;
          end
          left_e  <= left_v;
          right_e <= right_v;
          l_hi    <= (lhi_sum > (COORD_W + 1)'(WIDTH - 1)) ? SCOORD_W'(WIDTH - 1)
                                                           : SCOORD_W'(lhi_sum);
          r_lo    <= (right_v < {1'b0, rww}) ? '0 : right_v - {1'b0, rww};
          tracked <= missing_new <= MISS_W'(MISS_LIMIT);
          sum_l <= '0; sum_r <= '0; sum_b <= '0;
          cnt_l <= '0; cnt_r <= '0; cnt_b <= '0;
          if (missing_new <= MISS_W'(MISS_LIMIT)) begin
            state   <= S_WIN;
            scan_on <= 1'b1;
            sc      <= '0;
          end else begin
            state <= S_OUT;
          end
        end
        S_WIN: begin
          if (p_valid && rd_data) begin
            if (col >= SCOORD_W'(left_e) && col <= l_hi) begin
              sum_l <= sum_l + SUM_W'(col);
              cnt_l <= cnt_l + 1'b1;
            end
            if (col >= r_lo && col <= right_e) begin
              sum_r <= sum_r + SUM_W'(col);
              cnt_r <= cnt_r + 1'b1;
            end
            if (col > l_hi) begin
              sum_b <= sum_b + SUM_W'(col);
              cnt_b <= cnt_b + 1'b1;
            end
          end
          if (!scan_on && !p_valid) begin
            state <= S_DIV_L;
          end
        end
        S_DIV_L: begin
          if (!div_wait) begin
            if (div_req.start) begin
              div_wait <= 1'b1;
            end else begin
              c_l   <= cl_sat;
              state <= S_DIV_R;
            end
          end else if (div_rsp.done) begin
            div_wait <= 1'b0;
            c_l      <= {1'b0, div_rsp.quotient[COORD_W-1:0]};
            state    <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (!div_wait) begin
            if (div_req.start) begin
              div_wait <= 1'b1;
            end else begin
              c_r   <= cr_sat;
              state <= S_DIV_B;
            end
          end else if (div_rsp.done) begin
            div_wait <= 1'b0;
            c_r      <= {1'b0, div_rsp.quotient[COORD_W-1:0]};
            state    <= S_DIV_B;
          end
        end
        S_DIV_B: begin
          if (!div_wait) begin
            if (div_req.start) begin
              div_wait <= 1'b1;
            end else begin
              b_found <= 1'b0;
              c_b     <= '1;
              state   <= S_OUT;
            end
          end else if (div_rsp.done) begin
            div_wait <= 1'b0;
            b_found  <= 1'b1;
            c_b      <= {1'b0, div_rsp.quotient[COORD_W-1:0]};
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!results.valid || results.ready) begin
            results.valid          <= 1'b1;
            results.out_row        <= row_reg;
            results.row_tracked    <= tracked;
            results.raw_left_edge  <= edge_found ? SCOORD_W'(raw_l) : '1;
            results.raw_right_edge <= edge_found ? SCOORD_W'(raw_r) : '1;
            results.used_left_edge <= left_e;
            if (tracked) begin
              results.straight_center <= c_l;
              results.side_center     <= c_r;
              results.branch_found    <= b_found;
              results.branch_col      <= c_b;
              results.branch_count    <= cnt_b[COORD_W-1:0];
            end else begin
              results.straight_center <= '0;
              results.side_center     <= '0;
              results.branch_found    <= 1'b0;
              results.branch_col      <= '1;
              results.branch_count    <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> div_req.divisor != '0)
    else $error("divider started with zero divisor");

  a_row_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (acc && pixels.row_end) |=> !pixels.ready)
    else $error("pixel taken during row evaluation");

  a_cp_range: assert property (@(posedge clk) disable iff (rst)
    cp <= CPW'(WIDTH))
    else $error("column pointer past row width");

  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    scan_on |-> (state == S_EDGE || state == S_WIN))
    else $error("row memory scan outside a pass");
`endif
endmodule

// ===== hdl/rsdac_row_buf.sv =====
// rsdac_row_buf: one-bit row memory, one write and one registered read port
// depends on nothing but its parameter
module rsdac_row_buf #(
  parameter int WIDTH = 320
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(WIDTH)-1:0] wr_addr,
  input  logic                     wr_data,
  input  logic [$clog2(WIDTH)-1:0] rd_addr,
  output logic                     rd_data
);
  logic mem [WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hdl/rsdac_div.sv =====
// rsdac_div: restoring divider, one quotient bit per cycle
// depends on rsdac_pkg
module rsdac_div (
  input  logic                clk,
  input  logic                rst,
  input  rsdac_pkg::div_req_t req,
  output rsdac_pkg::div_rsp_t rsp
);
  import rsdac_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W-1:0]  rem_next;

  always_comb begin
    rem_sh   = {rem, dvd[SUM_W-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_next = ge ? CNT_W'(rem_sh - {1'b0, dsr}) : rem_sh[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem  <= rem_next;
        dvd  <= {dvd[SUM_W-2:0], ge};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;
endmodule

// ===== test/tb_row_scan_dual_anchor_centroid_unit.sv =====
// testbench of row_scan_dual_anchor_centroid_unit: pixel rows in, row results checked
// against an in-bench predictor; depends on rsdac_pkg, rsdac_if and the unit's rtl
`timescale 1ns / 100ps

module tb_row_scan_dual_anchor_centroid_unit;
  import rsdac_pkg::*;

  localparam int W          = WIDTH_DEF;
  localparam int MISS_MAX   = MISS_LIMIT_DEF;
  localparam int SETTLE     = 2 * W + 200;
  localparam int CYCLE_CAP  = 2000000;
  localparam int ROWS_PHASE = 4;

  typedef struct {
    logic [COORD_W-1:0]  row;
    logic                tracked;
    logic [SCOORD_W-1:0] straight;
    logic [SCOORD_W-1:0] side;
    logic                br_found;
    logic [SCOORD_W-1:0] br_center;
    logic [COORD_W-1:0]  br_count;
    logic [SCOORD_W-1:0] raw_l;
    logic [SCOORD_W-1:0] raw_r;
    logic [COORD_W-1:0]  used_l;
  } row_result_t;

  typedef struct {
    bit                 fb;
    int                 len;
    int                 dot;
    int                 fill_from;
    logic [COORD_W-1:0] rn;
    bit                 typed;
    int                 el;
    int                 er;
    bit                 et;
  } row_plan_t;

  typedef struct {
    bit on;
    int el;
    int er;
    bit et;
  } edge_pin_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [COORD_W-1:0] wr_data;

  rsdac_pixel_if  pix ();
  rsdac_result_if res ();

  row_scan_dual_anchor_centroid_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pix),
    .results  (res),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  row_result_t row_results_q[$];
  edge_pin_t   edge_pins_q[$];
  row_plan_t   plan[$];

  bit mask_row[W];
  int col_ptr, last_l, last_r, miss_cnt;
  int win_l, win_r, br_min;
  int mismatches;
  int cycles;
  int src_idle, snk_idle;

  always begin
    #10 clk = 1'b0;
    #10 clk = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) res.ready <= ($urandom_range(99) >= snk_idle);

  task report(input string field, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    mismatches++;
  endtask

  function automatic int sx(input logic [SCOORD_W-1:0] v);
    return int'($signed(v));
  endfunction

  task restart_track();
    col_ptr  = 0;
    miss_cnt = 0;
    last_l   = W / 2;
    last_r   = W / 2 + win_r / 2;
  endtask

  task predict_pixel(input bit p, input logic [COORD_W-1:0] rn, input bit re, input bit fb);
    int rl, rr, left, right, lhi, rlo, sum, cnt, bsum, bcnt, cl, cr, bmin;
    row_result_t r;
    edge_pin_t pin;
    if (fb) restart_track();
    if (col_ptr < W) begin
      mask_row[col_ptr] = p;
      col_ptr++;
    end
    if (!re) return;
    col_ptr = 0;
    rl = -1;
    rr = -1;
    for (int c = 0; c < W; c++) begin
      if (mask_row[c]) begin
        if (rl < 0) rl = c;
        rr = c;
      end
    end
    if (rl < 0) begin
      if (miss_cnt < 15) miss_cnt++;
      left  = last_l;
      right = last_r;
    end else begin
      miss_cnt = 0;
      last_l   = rl;
      last_r   = rr;
      left     = rl;
      right    = rr;
    end
    r.row     = rn;
    r.tracked = (miss_cnt <= MISS_MAX);
    r.raw_l   = rl[SCOORD_W-1:0];
    r.raw_r   = rr[SCOORD_W-1:0];
    r.used_l  = left[COORD_W-1:0];
    if (!r.tracked) begin
      r.straight  = '0;
      r.side      = '0;
      r.br_found  = 0;
      r.br_center = '1;
      r.br_count  = '0;
    end else begin
      lhi = left + win_l;
      if (lhi > W - 1) lhi = W - 1;
      sum = 0;
      cnt = 0;
      for (int c = left; c <= lhi; c++) begin
        if (c >= 0 && c < W && mask_row[c]) begin
          sum += c;
          cnt++;
        end
      end
      cl = cnt ? sum / cnt : left + win_l / 2;
      if (cl > 1023) cl = 1023;
      rlo = right - win_r;
      if (rlo < 0) rlo = 0;
      sum = 0;
      cnt = 0;
      for (int c = rlo; c <= right; c++) begin
        if (c >= 0 && c < W && mask_row[c]) begin
          sum += c;
          cnt++;
        end
      end
      cr = cnt ? sum / cnt : right - win_r / 2;
      if (cr > 1023) cr = 1023;
      bsum = 0;
      bcnt = 0;
      for (int c = lhi + 1; c < W; c++) begin
        if (c >= 0 && mask_row[c]) begin
          bsum += c;
          bcnt++;
        end
      end
      bmin = br_min ? br_min : 1;
      r.straight  = cl[SCOORD_W-1:0];
      r.side      = cr[SCOORD_W-1:0];
      r.br_found  = (bcnt >= bmin);
      r.br_center = (bcnt >= bmin) ? SCOORD_W'(bsum / bcnt) : '1;
      r.br_count  = bcnt[COORD_W-1:0];
    end
    pin = edge_pins_q.pop_front();
    if (pin.on) begin
      r.raw_l   = pin.el[SCOORD_W-1:0];
      r.raw_r   = pin.er[SCOORD_W-1:0];
      r.tracked = pin.et;
    end
    row_results_q.insert(row_results_q.size(), r);
  endtask

  always @(posedge clk) begin
    row_result_t e;
    if (rst) begin
      win_l  = LEFT_WIN_RST;
      win_r  = RIGHT_WIN_RST;
      br_min = BRANCH_MIN_RST;
      restart_track();
    end
    if (!rst && res.valid && res.ready) begin
      if (row_results_q.size() == 0) begin
        report("unexpected result, row", res.out_row, -1);
      end else begin
        e = row_results_q.pop_front();
        if (res.out_row != e.row) report("out_row", res.out_row, e.row);
        if (res.row_tracked != e.tracked) report("row_tracked", res.row_tracked, e.tracked);
        if (res.straight_center != e.straight)
          report("straight_center", sx(res.straight_center), sx(e.straight));
        if (res.side_center != e.side) report("side_center", sx(res.side_center), sx(e.side));
        if (res.branch_found != e.br_found) report("branch_found", res.branch_found, e.br_found);
        if (res.branch_col != e.br_center)
          report("branch_col", sx(res.branch_col), sx(e.br_center));
        if (res.branch_count != e.br_count) report("branch_count", res.branch_count, e.br_count);
        if (res.raw_left_edge != e.raw_l)
          report("raw_left_edge", sx(res.raw_left_edge), sx(e.raw_l));
        if (res.raw_right_edge != e.raw_r)
          report("raw_right_edge", sx(res.raw_right_edge), sx(e.raw_r));
        if (res.used_left_edge != e.used_l)
          report("used_left_edge", res.used_left_edge, e.used_l);
      end
    end
    if (!rst && wr_en) begin
      case (wr_index)
        REG_LEFT_WIN:   win_l  = wr_data;
        REG_RIGHT_WIN:  win_r  = wr_data;
        REG_BRANCH_MIN: br_min = wr_data;
        default: ;
      endcase
    end
    if (!rst && pix.valid && pix.ready)
      predict_pixel(pix.pixel, pix.row_number, pix.row_end, pix.frame_begin);
  end

  task send_pixel(input bit p, input logic [COORD_W-1:0] rn, input bit re, input bit fb);
    while ($urandom_range(99) < src_idle) begin
      pix.valid <= 0;
      @(negedge clk);
    end
    pix.valid       <= 1;
    pix.pixel       <= p;
    pix.row_number  <= rn;
    pix.row_end     <= re;
    pix.frame_begin <= fb;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task send_plan_row(input row_plan_t pl);
    edge_pin_t pin;
    pin = '{pl.typed, pl.el, pl.er, pl.et};
    edge_pins_q.insert(edge_pins_q.size(), pin);
    for (int c = 0; c < pl.len; c++)
      send_pixel((c == pl.dot) || (c >= pl.fill_from), pl.rn, c == pl.len - 1,
                 pl.fb && c == 0);
  endtask

  task send_random_row();
    int len, dens, pick;
    logic [COORD_W-1:0] rn;
    edge_pin_t pin;
    pick = $urandom_range(99);
    len  = pick < 97 ? $urandom_range(1, 30) : pick < 99 ? W : $urandom_range(W + 1, W + 20);
    case ($urandom_range(3))
      0: dens = 0;
      1: dens = 5;
      2: dens = 50;
      default: dens = 95;
    endcase
    rn  = COORD_W'($urandom);
    pin = '{0, 0, 0, 0};
    edge_pins_q.insert(edge_pins_q.size(), pin);
    for (int c = 0; c < len; c++)
      send_pixel($urandom_range(99) < dens, rn, c == len - 1,
                 (c == 0 && $urandom_range(7) == 0) || $urandom_range(199) == 0);
  endtask

  task drain();
    pix.valid <= 0;
    while (row_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_reg(input cfg_reg_t idx, input logic [COORD_W-1:0] data);
    wr_en    <= 1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en <= 0;
    @(negedge clk);
  endtask

  initial begin
    rst             = 1;
    wr_en           = 0;
    wr_index        = REG_LEFT_WIN;
    wr_data         = '0;
    pix.valid       = 0;
    pix.pixel       = 0;
    pix.row_number  = '0;
    pix.row_end     = 0;
    pix.frame_begin = 0;
    src_idle        = 23;
    snk_idle        = 72;

    // a full empty row first so that every column is written before a short row
    plan.insert(plan.size(), '{1, W, 1023, 1023, 10'd0, 1, -1, -1, 1});
    for (int k = 0; k < 6; k++)
      plan.insert(plan.size(), '{0, 1, 1023, 1023, 10'(k + 1), 1, -1, -1,
                                 k + 2 <= MISS_MAX});
    plan.insert(plan.size(), '{1, 1, 1023, 1023, 10'd20, 1, -1, -1, 1});
    plan.insert(plan.size(), '{0, 10, 3, 1023, 10'd21, 1, 3, 3, 1});
    plan.insert(plan.size(), '{0, 1, 0, 1023, 10'd22, 1, 0, 3, 1});
    plan.insert(plan.size(), '{0, W + 5, 40, 250, 10'd1023, 1, 40, W - 1, 1});
    plan.insert(plan.size(), '{0, 30, 1023, 1023, 10'd24, 0, 0, 0, 0});
    plan.insert(plan.size(), '{0, 1, 0, 0, 10'd25, 1, 0, W - 1, 1});

    repeat (8) @(negedge clk);
    rst = 0;

    foreach (plan[i]) send_plan_row(plan[i]);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      src_idle = ph == 0 ? 23 : ph == 1 ? 72 : 0;
      snk_idle = ph == 0 ? 72 : ph == 1 ? 23 : 0;
      case (ph)
        1: begin
          write_reg(REG_LEFT_WIN, 10'd0);
          write_reg(REG_RIGHT_WIN, 10'd0);
          write_reg(REG_BRANCH_MIN, 10'd0);
        end
        2: begin
          write_reg(REG_LEFT_WIN, 10'd1023);
          write_reg(REG_RIGHT_WIN, 10'd1023);
          write_reg(REG_BRANCH_MIN, 10'd1023);
        end
        3: begin
          write_reg(REG_LEFT_WIN, 10'($urandom_range(1, 200)));
          write_reg(REG_RIGHT_WIN, 10'($urandom_range(1, 200)));
          write_reg(REG_BRANCH_MIN, 10'($urandom_range(1, 40)));
        end
        default: ;
      endcase
      for (int n = 0; n < ROWS_PHASE; n++) send_random_row();
    end

    drain();
    if (mismatches == 0 && row_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rsdac_pkg.sv
hdl/rsdac_if.sv
hdl/rsdac_row_buf.sv
hdl/rsdac_div.sv
hdl/row_scan_dual_anchor_centroid_unit.sv
test/tb_row_scan_dual_anchor_centroid_unit.sv
